FILE: hdl/i64dr_pkg.sv
// Shared types for the 64-bit restoring divider.
// Holds the request and result structs; no dependencies.
package i64dr_pkg;

  // Width of every data field on the ports.
  localparam int unsigned DATA_W = 64;

  // One division request.
  typedef struct packed {
    logic              op;        // 0 unsigned, 1 signed
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } req_t;

  // One division result.
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              div_by_zero;
  } res_t;

endpackage

FILE: hdl/int64_divide_remainder.sv
// Top level of the radix-2 restoring divider.
// Depends on i64dr_pkg for the request and result structs and on i64dr_sub.
//
// A request is taken when start is high and busy is low. Unsigned division
// runs the WIDTH shift-subtract steps and then the finishing step; signed
// division adds the negation of the operands before them and of the results
// after them. The single shared subtractor produces one quotient bit per
// cycle and also performs the negations of operands and results. A zero
// divisor skips all of that and goes from the request straight to the
// finishing step, with no negation, in either
// mode. The result appears on out_res for exactly one cycle with out_valid
// high and cannot be held off, so the receiver must take it then. A zero
// divisor gives an all-ones quotient, the dividend as remainder and
// div_by_zero set. Only the low WIDTH bits of the operands are used; result
// bits above WIDTH are zero.
module int64_divide_remainder #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  i64dr_pkg::req_t  in_req,
  output logic             out_valid,
  output i64dr_pkg::res_t  out_res
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_N,
    ST_NEG_D,
    ST_DIV,
    ST_FIX_Q,
    ST_FIX_R,
    ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WIDTH-1:0]   qr_r, qr_nxt;      // dividend, then quotient
  logic [WIDTH-1:0]   rem_r, rem_nxt;
  logic [WIDTH-1:0]   d_r, d_nxt;
  logic               signed_r, signed_nxt;
  logic               n_neg_r, n_neg_nxt;
  logic               q_neg_r, q_neg_nxt;
  logic               dz_r, dz_nxt;
  logic               out_valid_r, out_valid_nxt;
  i64dr_pkg::res_t    out_res_r, out_res_nxt;

  logic [WIDTH-1:0]   in_n;
  logic [WIDTH-1:0]   in_d;
  logic [WIDTH:0]     sub_a;
  logic [WIDTH:0]     sub_b;
  logic [WIDTH:0]     sub_diff;
  logic               sub_borrow;

  assign in_n = in_req.dividend[WIDTH-1:0];
  assign in_d = in_req.divisor[WIDTH-1:0];

  // Operand selection for the shared subtractor.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      ST_NEG_N: sub_b = {1'b0, qr_r};
      ST_NEG_D: sub_b = {1'b0, d_r};
      ST_DIV: begin
        sub_a = {rem_r, qr_r[WIDTH-1]};
        sub_b = {1'b0, d_r};
      end
      ST_FIX_Q: sub_b = {1'b0, qr_r};
      ST_FIX_R: sub_b = {1'b0, rem_r};
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  i64dr_sub #(
    .WIDTH (WIDTH)
  ) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // Sequencer: load (a zero divisor goes straight to the finish), optional operand
  // negation, WIDTH shift-subtract steps, optional result negation, then one cycle of result strobe.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    qr_nxt        = qr_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    signed_nxt    = signed_r;
    n_neg_nxt     = n_neg_r;
    q_neg_nxt     = q_neg_r;
    dz_nxt        = dz_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          qr_nxt     = in_n;
          d_nxt      = in_d;
          rem_nxt    = '0;
          cnt_nxt    = CNT_W'(WIDTH - 1);
          signed_nxt = in_req.op;
          n_neg_nxt  = in_req.op & in_n[WIDTH-1];
          q_neg_nxt  = in_req.op & (in_n[WIDTH-1] ^ in_d[WIDTH-1]);
          dz_nxt     = (in_d == '0);
          if (in_d == '0) begin
            qr_nxt    = '1;
            rem_nxt   = in_n;
            state_nxt = ST_FINISH;
          end else if (in_req.op) begin
            state_nxt = ST_NEG_N;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_NEG_N: begin
        if (n_neg_r) begin
          qr_nxt = sub_diff[WIDTH-1:0];
        end
        state_nxt = ST_NEG_D;
      end
      ST_NEG_D: begin
        if (d_r[WIDTH-1]) begin
          d_nxt = sub_diff[WIDTH-1:0];
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Keep the difference when the partial remainder reaches the divisor.
        if (!sub_borrow) begin
          rem_nxt = sub_diff[WIDTH-1:0];
        end else begin
          rem_nxt = sub_a[WIDTH-1:0];
        end
        qr_nxt  = {qr_r[WIDTH-2:0], ~sub_borrow};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = signed_r ? ST_FIX_Q : ST_FINISH;
        end
      end
      ST_FIX_Q: begin
        if (q_neg_r) begin
          qr_nxt = sub_diff[WIDTH-1:0];
        end
        state_nxt = ST_FIX_R;
      end
      ST_FIX_R: begin
        if (n_neg_r) begin
          rem_nxt = sub_diff[WIDTH-1:0];
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        out_valid_nxt           = 1'b1;
        out_res_nxt.quotient    = i64dr_pkg::DATA_W'(qr_r);
        out_res_nxt.remainder   = i64dr_pkg::DATA_W'(rem_r);
        out_res_nxt.div_by_zero = dz_r;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, working registers and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r     <= cnt_nxt;
    qr_r      <= qr_nxt;
    rem_r     <= rem_nxt;
    d_r       <= d_nxt;
    signed_r  <= signed_nxt;
    n_neg_r   <= n_neg_nxt;
    q_neg_r   <= q_neg_nxt;
    dz_r      <= dz_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A request taken always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but divider not busy");

  // A result strobe only follows the finishing step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FINISH))
    else $error("result strobe without finishing step");

  // The divider is free again while the result is shown.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("divider busy during result strobe");

  // A zero divisor always reports an all-ones quotient.
  a_dz_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.div_by_zero) |-> (out_res.quotient[WIDTH-1:0] == {WIDTH{1'b1}}))
    else $error("division by zero without all-ones quotient");

endmodule

FILE: hdl/i64dr_sub.sv
// Shared subtractor of the divider: one (W+1)-bit subtract with borrow.
// Used for every trial subtraction and every negation; no package needed.
module i64dr_sub #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH:0] a,
  input  logic [WIDTH:0] b,
  output logic [WIDTH:0] diff,
  output logic           borrow
);

  logic [WIDTH+1:0] full;

  // Extend by one bit so that the top bit of the result is the borrow.
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[WIDTH:0];
  assign borrow = full[WIDTH+1];

endmodule
